### design/mcft_pkg.sv
package mcft_pkg;

  // fixed point format and store layout
  localparam int FRAC_BITS    = 16;
  localparam int CORNER_COUNT = 4;
  localparam int HOM_BASE     = 0;
  localparam int BLEND_BASE   = 9;
  localparam int CORNER_WORDS = 12;
  localparam int STORE_DEPTH  = BLEND_BASE + CORNER_WORDS * CORNER_COUNT;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int EPS_Q        = ((2 ** FRAC_BITS) + 50) / 100;

  // internal widths
  localparam int SUM_W  = 50;  // row sums, squared distance
  localparam int NUM_W  = 42;  // blend accumulators, divider dividend
  localparam int DEN_W  = 50;  // divider divisor
  localparam int GRID_W = 31;

  localparam logic signed [31:0] MAX32 = 32'sh7fffffff;
  localparam logic signed [31:0] MIN32 = 32'sh80000000;

  // commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_XFORM = 1'b1;

  // transform modes
  localparam logic [1:0] MODE_PASS   = 2'd0;
  localparam logic [1:0] MODE_PLANAR = 2'd1;
  localparam logic [1:0] MODE_BLEND  = 2'd2;

  // config register indexes
  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_GRID_W = 2'd1;
  localparam logic [1:0] CFG_GRID_H = 2'd2;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic               fault;
    logic signed [31:0] quot;
  } div_rsp_t;

  // clamp to 32 signed bits
  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [31:0] r;
    if ((&v[SUM_W-1:31]) || !(|v[SUM_W-1:31])) r = v[31:0];
    else if (v[SUM_W-1]) r = MIN32;
    else r = MAX32;
    return r;
  endfunction

  // product rounded to FRAC_BITS fraction bits, ties up
  function automatic logic signed [SUM_W-1:0] round_prod(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + (64'sd1 <<< (FRAC_BITS - 1));
    return SUM_W'(t >>> FRAC_BITS);
  endfunction

endpackage

### design/mcft_ram.sv
module mcft_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 57
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/mcft_mul.sv
module mcft_mul (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [63:0] prod_o
);

  logic signed [63:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) prod_q <= 64'(a_i) * 64'(b_i);
  end

  assign prod_o = prod_q;

endmodule

### design/mcft_div.sv
module mcft_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mcft_pkg::div_req_t  req_i,
  output mcft_pkg::div_rsp_t  rsp_o
);

  localparam int QBITS = 32;
  localparam int CNT_W = $clog2(QBITS + 1);
  localparam int SHIFT = QBITS - mcft_pkg::FRAC_BITS;
  localparam int NW    = mcft_pkg::NUM_W;
  localparam int DW    = mcft_pkg::DEN_W;

  typedef enum logic [1:0] {
    DV_IDLE = 2'b01,
    DV_RUN  = 2'b10
  } dv_state_e;

  dv_state_e          st_q, st_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [DW-1:0]      rem_q, rem_d;
  logic [DW-1:0]      ud_q, ud_d;
  logic [QBITS-1:0]   sh_q, sh_d;
  logic [QBITS-1:0]   quo_q, quo_d;
  logic               neg_q, neg_d;
  logic               done_q, done_d;
  logic               fault_q, fault_d;
  logic signed [31:0] res_q, res_d;

  logic [NW-1:0] un;
  logic [DW-1:0] ud;
  logic [NW-1:0] hi;
  logic          ovf;
  logic [DW:0]   trial;
  logic          ge;
  logic [QBITS-1:0] quo_n;

  function automatic logic signed [31:0] fix_sign(input logic neg, input logic sat,
                                                  input logic [31:0] m);
    logic signed [31:0] r;
    if (neg) r = (sat || (m[31] && (|m[30:0]))) ? mcft_pkg::MIN32 : $signed(~m + 32'd1);
    else r = (sat || m[31]) ? mcft_pkg::MAX32 : $signed(m);
    return r;
  endfunction

  always_comb begin
    un    = req_i.num[NW-1] ? NW'(-req_i.num) : NW'(req_i.num);
    ud    = req_i.den[DW-1] ? DW'(-req_i.den) : DW'(req_i.den);
    hi    = un >> SHIFT;
    ovf   = DW'(hi) >= ud;
    trial = {rem_q, sh_q[QBITS-1]};
    ge    = trial >= {1'b0, ud_q};
    quo_n = {quo_q[QBITS-2:0], ge};
  end

  always_comb begin
    st_d    = st_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    ud_d    = ud_q;
    sh_d    = sh_q;
    quo_d   = quo_q;
    neg_d   = neg_q;
    done_d  = 1'b0;
    fault_d = fault_q;
    res_d   = res_q;
    case (st_q)
      DV_IDLE: begin
        if (req_i.start) begin
          neg_d   = req_i.num[NW-1] ^ req_i.den[DW-1];
          fault_d = 1'b0;
          if (ud == '0) begin
            // zero divisor: saturate by the dividend sign
            res_d   = req_i.num[NW-1] ? mcft_pkg::MIN32 : mcft_pkg::MAX32;
            fault_d = 1'b1;
            done_d  = 1'b1;
          end else if (ovf) begin
            res_d  = fix_sign(req_i.num[NW-1] ^ req_i.den[DW-1], 1'b1, '0);
            done_d = 1'b1;
          end else begin
            rem_d = DW'(hi);
            ud_d  = ud;
            sh_d  = QBITS'({un, {mcft_pkg::FRAC_BITS{1'b0}}});
            quo_d = '0;
            cnt_d = CNT_W'(QBITS);
            st_d  = DV_RUN;
          end
        end
      end
      DV_RUN: begin
        rem_d = ge ? DW'(trial - {1'b0, ud_q}) : DW'(trial);
        quo_d = quo_n;
        sh_d  = {sh_q[QBITS-2:0], 1'b0};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          res_d  = fix_sign(neg_q, 1'b0, quo_n);
          done_d = 1'b1;
          st_d   = DV_IDLE;
        end
      end
      default: st_d = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= DV_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    rem_q   <= rem_d;
    ud_q    <= ud_d;
    sh_q    <= sh_d;
    quo_q   <= quo_d;
    neg_q   <= neg_d;
    fault_q <= fault_d;
    res_q   <= res_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.fault = fault_q;
  assign rsp_o.quot  = res_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> st_q == DV_IDLE)
    else $error("divide started while busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("divide done longer than one cycle");

endmodule

### design/marker_coordinate_frame_transform.sv
// throughput: one item at a time; the input is ready only while the sequencer is idle
// rate is set by the shared bit-serial divider (4 quotients per item in planar mode, 14 in 3d
// mode) and the single shared multiplier
// reset: asynchronous active low; clears the sequencer, the output valid and the mode and
// grid registers; the coefficient store is not cleared and holds garbage until written
module marker_coordinate_frame_transform (
  input  logic               clk_i,
  input  logic               rst_ni,
  // config write port
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [30:0]        cfg_data_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  input  logic [5:0]         coef_index_i,
  input  logic signed [31:0] coef_value_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] norm_x_i,
  input  logic signed [31:0] norm_y_i,
  input  logic signed [31:0] norm_z_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic signed [31:0] out_nx_o,
  output logic signed [31:0] out_ny_o,
  output logic signed [31:0] out_nz_o,
  output logic               divide_fault_o
);

  localparam int AW = mcft_pkg::ADDR_W;
  localparam int SW = mcft_pkg::SUM_W;
  localparam int NW = mcft_pkg::NUM_W;
  localparam int DW = mcft_pkg::DEN_W;

  // sequencer states, one-hot
  typedef enum logic [18:0] {
    ST_IDLE    = 19'd1,
    ST_TD_RD   = 19'd2,
    ST_TD      = 19'd4,
    ST_SQ_MUL  = 19'd8,
    ST_SQ_ACC  = 19'd16,
    ST_WDIV    = 19'd32,
    ST_ROW_RD  = 19'd64,
    ST_ROW_MUL = 19'd128,
    ST_ROW_ACC = 19'd256,
    ST_MIRROR  = 19'd512,
    ST_BL_MUL  = 19'd1024,
    ST_BL_ACC  = 19'd2048,
    ST_RDIV    = 19'd4096,
    ST_UV_DIV  = 19'd8192,
    ST_HOM_RD  = 19'd16384,
    ST_HOM_MUL = 19'd32768,
    ST_HOM_ACC = 19'd65536,
    ST_HDIV    = 19'd131072,
    ST_DONE    = 19'd262144
  } state_e;

  // config registers
  logic [1:0]        mode_q;
  logic [30:0]       grid_w_q, grid_h_q;

  // control
  state_e            st_q, st_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic [1:0]        k_q, k_d, j_q, j_d, corner_q, corner_d;
  logic              vsel_q, vsel_d;
  logic              pend_q, pend_d;
  logic              out_valid_q, out_valid_d;

  // datapath
  logic signed [31:0]   pin_q [3], pin_d [3];
  logic signed [31:0]   nin_q [3], nin_d [3];
  logic signed [31:0]   t_q [3], t_d [3];
  logic signed [31:0]   r_q [3], r_d [3];
  logic signed [SW-1:0] sum_q, sum_d;
  logic signed [31:0]   w_q, w_d;
  logic signed [NW-1:0] bacc_q [3], bacc_d [3];
  logic signed [31:0]   wsum_q, wsum_d;
  logic signed [31:0]   resp_q [3], resp_d [3];
  logic signed [31:0]   resn_q [3], resn_d [3];
  logic                 fault_q, fault_d;
  logic signed [31:0]   outv_q [6];
  logic                 out_fault_q;

  logic               in_fire, load;
  logic               ram_we, ram_re;
  logic [31:0]        ram_rdata;
  logic signed [31:0] rdata;
  logic               mul_en;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic signed [SW-1:0] rnd;
  logic signed [31:0] vec_k;
  logic signed [32:0] diff;
  logic               last_corner;
  mcft_pkg::div_req_t div_req;
  mcft_pkg::div_rsp_t div_rsp;

  assign in_ready_o = (st_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign load       = (st_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // coefficient store: written on an accepted write beat with an in-range index, read by the sequencer
  assign ram_we = in_fire && (command_i == mcft_pkg::CMD_WRITE) &&
                  (coef_index_i < mcft_pkg::STORE_DEPTH);
  assign ram_re = (st_q == ST_TD_RD) || (st_q == ST_ROW_RD) || (st_q == ST_HOM_RD);

  mcft_ram #(
    .WIDTH(32),
    .DEPTH(mcft_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(AW'(coef_index_i)),
    .wdata_i(coef_value_i),
    .re_i   (ram_re),
    .raddr_i(ptr_q),
    .rdata_o(ram_rdata)
  );

  assign rdata = $signed(ram_rdata);

  // shared multiplier, product registered
  always_comb begin
    mul_en = 1'b1;
    mul_a  = t_q[k_q];
    mul_b  = t_q[k_q];
    case (st_q)
      ST_ROW_MUL: begin
        mul_a = rdata;
        mul_b = t_q[k_q];
      end
      ST_BL_MUL: begin
        mul_a = w_q;
        mul_b = r_q[j_q];
      end
      ST_HOM_MUL: begin
        mul_a = rdata;
        mul_b = (k_q == 2'd0) ? t_q[0] : t_q[1];
      end
      ST_SQ_MUL: mul_en = 1'b1;
      default: mul_en = 1'b0;
    endcase
  end

  mcft_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .prod_o(prod)
  );

  assign rnd = mcft_pkg::round_prod(prod);

  // shared divider requests
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = NW'(bacc_q[j_q]);
    div_req.den   = DW'(wsum_q);
    case (st_q)
      ST_WDIV: begin
        div_req.start = !pend_q;
        div_req.num   = NW'(1) << mcft_pkg::FRAC_BITS;
        div_req.den   = DW'(sum_q);
      end
      ST_RDIV: div_req.start = !pend_q;
      ST_UV_DIV: begin
        div_req.start = !pend_q;
        div_req.num   = -NW'((j_q == 2'd0) ? pin_q[1] : pin_q[2]);
        div_req.den   = DW'(pin_q[0]);
      end
      ST_HDIV: begin
        div_req.start = !pend_q;
        div_req.num   = NW'(r_q[j_q]);
        div_req.den   = DW'(r_q[2]);
      end
      default: div_req.start = 1'b0;
    endcase
  end

  mcft_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign vec_k       = vsel_q ? nin_q[k_q] : pin_q[k_q];
  assign diff        = 33'(vec_k) - 33'(rdata);
  assign last_corner = (corner_q == 2'(mcft_pkg::CORNER_COUNT - 1));

  // sequencer
  always_comb begin
    st_d        = st_q;
    ptr_d       = ptr_q;
    k_d         = k_q;
    j_d         = j_q;
    corner_d    = corner_q;
    vsel_d      = vsel_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    pin_d       = pin_q;
    nin_d       = nin_q;
    t_d         = t_q;
    r_d         = r_q;
    sum_d       = sum_q;
    w_d         = w_q;
    bacc_d      = bacc_q;
    wsum_d      = wsum_q;
    resp_d      = resp_q;
    resn_d      = resn_q;
    fault_d     = fault_q;

    if (div_req.start) pend_d = 1'b1;
    if (div_rsp.done) pend_d = 1'b0;

    if (load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;

    case (st_q)
      ST_IDLE: begin
        if (in_fire && (command_i == mcft_pkg::CMD_XFORM)) begin
          pin_d   = '{pos_x_i, pos_y_i, pos_z_i};
          nin_d   = '{norm_x_i, norm_y_i, norm_z_i};
          fault_d = 1'b0;
          j_d     = 2'd0;
          k_d     = 2'd0;
          case (mode_q)
            mcft_pkg::MODE_PLANAR: st_d = ST_UV_DIV;
            mcft_pkg::MODE_BLEND: begin
              vsel_d   = 1'b0;
              corner_d = 2'd0;
              ptr_d    = AW'(mcft_pkg::BLEND_BASE);
              bacc_d   = '{default: '0};
              wsum_d   = '0;
              st_d     = ST_TD_RD;
            end
            default: begin
              resp_d = '{pos_x_i, pos_y_i, pos_z_i};
              resn_d = '{norm_x_i, norm_y_i, norm_z_i};
              st_d   = ST_DONE;
            end
          endcase
        end
      end
      // offset from the corner: t = v - offset
      ST_TD_RD: begin
        ptr_d = ptr_q + AW'(1);
        st_d  = ST_TD;
      end
      ST_TD: begin
        t_d[k_q] = mcft_pkg::sat32(SW'(diff));
        if (k_q == 2'd2) begin
          k_d   = 2'd0;
          sum_d = SW'(mcft_pkg::EPS_Q);
          st_d  = ST_SQ_MUL;
        end else begin
          k_d  = k_q + 2'd1;
          st_d = ST_TD_RD;
        end
      end
      // squared distance plus epsilon
      ST_SQ_MUL: st_d = ST_SQ_ACC;
      ST_SQ_ACC: begin
        sum_d = sum_q + rnd;
        if (k_q == 2'd2) begin
          k_d  = 2'd0;
          st_d = ST_WDIV;
        end else begin
          k_d  = k_q + 2'd1;
          st_d = ST_SQ_MUL;
        end
      end
      // corner weight 1/d
      ST_WDIV: begin
        if (div_rsp.done) begin
          w_d   = div_rsp.quot;
          sum_d = '0;
          j_d   = 2'd0;
          k_d   = 2'd0;
          st_d  = ST_ROW_RD;
        end
      end
      // corner matrix times t, one product per pass
      ST_ROW_RD: begin
        ptr_d = ptr_q + AW'(1);
        st_d  = ST_ROW_MUL;
      end
      ST_ROW_MUL: st_d = ST_ROW_ACC;
      ST_ROW_ACC: begin
        if (k_q == 2'd2) begin
          r_d[j_q] = mcft_pkg::sat32(sum_q + rnd);
          sum_d    = '0;
          k_d      = 2'd0;
          if (j_q == 2'd2) begin
            st_d = ST_MIRROR;
          end else begin
            j_d  = j_q + 2'd1;
            st_d = ST_ROW_RD;
          end
        end else begin
          sum_d = sum_q + rnd;
          k_d   = k_q + 2'd1;
          st_d  = ST_ROW_RD;
        end
      end
      // mirror by corner: odd corners flip x, upper corners flip y, diagonal flips z
      ST_MIRROR: begin
        if (corner_q[0])
          r_d[0] = mcft_pkg::sat32(SW'($signed({1'b0, grid_w_q})) - SW'(r_q[0]));
        if (corner_q[1])
          r_d[1] = mcft_pkg::sat32(SW'($signed({1'b0, grid_h_q})) - SW'(r_q[1]));
        if ((corner_q == 2'd0) || (corner_q == 2'd3))
          r_d[2] = mcft_pkg::sat32(-SW'(r_q[2]));
        wsum_d = wsum_q + w_q;
        j_d    = 2'd0;
        st_d   = ST_BL_MUL;
      end
      // weighted accumulate
      ST_BL_MUL: st_d = ST_BL_ACC;
      ST_BL_ACC: begin
        bacc_d[j_q] = bacc_q[j_q] + NW'(rnd);
        if (j_q == 2'd2) begin
          j_d = 2'd0;
          k_d = 2'd0;
          if (last_corner) begin
            st_d = ST_RDIV;
          end else begin
            corner_d = corner_q + 2'd1;
            st_d     = ST_TD_RD;
          end
        end else begin
          j_d  = j_q + 2'd1;
          st_d = ST_BL_MUL;
        end
      end
      // normalize by the weight sum
      ST_RDIV: begin
        if (div_rsp.done) begin
          if (vsel_q) resn_d[j_q] = div_rsp.quot;
          else resp_d[j_q] = div_rsp.quot;
          fault_d = fault_q | div_rsp.fault;
          if (j_q == 2'd2) begin
            j_d = 2'd0;
            if (vsel_q) begin
              st_d = ST_DONE;
            end else begin
              vsel_d   = 1'b1;
              corner_d = 2'd0;
              ptr_d    = AW'(mcft_pkg::BLEND_BASE);
              bacc_d   = '{default: '0};
              wsum_d   = '0;
              st_d     = ST_TD_RD;
            end
          end else begin
            j_d = j_q + 2'd1;
          end
        end
      end
      // planar: u = -y/x, v = -z/x
      ST_UV_DIV: begin
        if (div_rsp.done) begin
          t_d[j_q] = div_rsp.quot;
          fault_d  = fault_q | div_rsp.fault;
          if (j_q == 2'd1) begin
            resp_d = '{t_q[0], div_rsp.quot, 32'sd0};
            resn_d = '{default: '0};
            j_d    = 2'd0;
            k_d    = 2'd0;
            if (pin_q[0] == '0) begin
              st_d = ST_DONE;
            end else begin
              ptr_d = AW'(mcft_pkg::HOM_BASE);
              sum_d = '0;
              st_d  = ST_HOM_RD;
            end
          end else begin
            j_d = 2'd1;
          end
        end
      end
      // homography row: h0*u + h1*v + h2
      ST_HOM_RD: begin
        ptr_d = ptr_q + AW'(1);
        st_d  = (k_q == 2'd2) ? ST_HOM_ACC : ST_HOM_MUL;
      end
      ST_HOM_MUL: st_d = ST_HOM_ACC;
      ST_HOM_ACC: begin
        if (k_q == 2'd2) begin
          r_d[j_q] = mcft_pkg::sat32(sum_q + SW'(rdata));
          sum_d    = '0;
          k_d      = 2'd0;
          if (j_q == 2'd2) begin
            j_d  = 2'd0;
            st_d = ST_HDIV;
          end else begin
            j_d  = j_q + 2'd1;
            st_d = ST_HOM_RD;
          end
        end else begin
          sum_d = sum_q + rnd;
          k_d   = k_q + 2'd1;
          st_d  = ST_HOM_RD;
        end
      end
      // projective divide by the third term
      ST_HDIV: begin
        if (div_rsp.done) begin
          resp_d[j_q] = div_rsp.quot;
          fault_d     = fault_q | div_rsp.fault;
          if (j_q == 2'd1) st_d = ST_DONE;
          else j_d = 2'd1;
        end
      end
      ST_DONE: begin
        if (load) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // control and config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= mcft_pkg::MODE_PASS;
      grid_w_q    <= '0;
      grid_h_q    <= '0;
    end else begin
      st_q        <= st_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          mcft_pkg::CFG_MODE:   mode_q   <= cfg_data_i[1:0];
          mcft_pkg::CFG_GRID_W: grid_w_q <= cfg_data_i;
          mcft_pkg::CFG_GRID_H: grid_h_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    k_q      <= k_d;
    j_q      <= j_d;
    corner_q <= corner_d;
    vsel_q   <= vsel_d;
    pin_q    <= pin_d;
    nin_q    <= nin_d;
    t_q      <= t_d;
    r_q      <= r_d;
    sum_q    <= sum_d;
    w_q      <= w_d;
    bacc_q   <= bacc_d;
    wsum_q   <= wsum_d;
    resp_q   <= resp_d;
    resn_q   <= resn_d;
    fault_q  <= fault_d;
    if (load) begin
      outv_q      <= '{resp_q[0], resp_q[1], resp_q[2], resn_q[0], resn_q[1], resn_q[2]};
      out_fault_q <= fault_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_x_o        = outv_q[0];
  assign out_y_o        = outv_q[1];
  assign out_z_o        = outv_q[2];
  assign out_nx_o       = outv_q[3];
  assign out_ny_o       = outv_q[4];
  assign out_nz_o       = outv_q[5];
  assign divide_fault_o = out_fault_q;

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> ptr_q < mcft_pkg::STORE_DEPTH)
    else $error("coefficient read beyond the store");

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (command_i == mcft_pkg::CMD_WRITE)) |=> st_q == ST_IDLE)
    else $error("coefficient write left the idle state");

  a_blend_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (command_i == mcft_pkg::CMD_XFORM) && (mode_q == mcft_pkg::MODE_BLEND))
    |=> (st_q == ST_TD_RD) && (ptr_q == AW'(mcft_pkg::BLEND_BASE)))
    else $error("blend did not start at the first corner");

  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> pend_q)
    else $error("divider result with no request pending");

endmodule

### dv/testbench.sv
module testbench;
  import mcft_pkg::*;

  // one input beat as the sender sees it
  typedef struct {
    logic               cmd;
    logic [5:0]         idx;
    logic signed [31:0] val;
    logic signed [31:0] pos [3];
    logic signed [31:0] nrm [3];
  } beat_t;

  // one expected output beat
  typedef struct {
    logic signed [31:0] fld [6];
    logic               fault;
  } frame_t;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;
  localparam int     SETTLE_CYCLES = 1200;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [1:0]         cfg_index_i;
  logic [30:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               command_i;
  logic [5:0]         coef_index_i;
  logic signed [31:0] coef_value_i;
  logic signed [31:0] pos_x_i, pos_y_i, pos_z_i;
  logic signed [31:0] norm_x_i, norm_y_i, norm_z_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] out_x_o, out_y_o, out_z_o;
  logic signed [31:0] out_nx_o, out_ny_o, out_nz_o;
  logic               divide_fault_o;

  marker_coordinate_frame_transform dut (.*);

  // shadow copy of the block's state and registers
  logic signed [31:0] coef_shadow [STORE_DEPTH];
  logic [1:0]         mode_shadow;
  longint             grid_w_shadow, grid_h_shadow;

  beat_t  pending_q [$];
  frame_t frame_q [$];
  beat_t  cur_beat;
  int     send_idle_pct, recv_idle_pct;
  bit     send_hold;
  int     err_count;

  // ---------------------------------------------------------------------------
  // fixed point helpers
  // ---------------------------------------------------------------------------

  function automatic longint clamp32(longint v);
    return v > SAT_HI ? SAT_HI : (v < SAT_LO ? SAT_LO : v);
  endfunction

  // rounded product, ties toward plus infinity (arithmetic shift is a floor)
  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b + (64'sd1 <<< (FRAC_BITS - 1));
    return p >>> FRAC_BITS;
  endfunction

  // truncating quotient, saturated; zero divisor flags a fault
  function automatic longint qquot(longint n, longint d, inout bit fault);
    longint unsigned un, ud, q, r, m;
    bit neg;
    if (d == 0) begin
      fault = 1'b1;
      return n < 0 ? SAT_LO : SAT_HI;
    end
    neg = (n < 0) != (d < 0);
    un  = n < 0 ? -n : n;
    ud  = d < 0 ? -d : d;
    q   = un / ud;
    r   = un % ud;
    if (q >= (64'd1 << (32 - FRAC_BITS))) m = 64'd1 << 32;
    else m = (q << FRAC_BITS) + ((r << FRAC_BITS) / ud);
    if (neg) return m > (64'd1 << 31) ? SAT_LO : -longint'(m);
    return m > 64'd2147483647 ? SAT_HI : longint'(m);
  endfunction

  // inverse squared distance blend of the mirrored corner transforms
  function automatic void corner_blend(input longint v [3], output longint res [3],
                                       inout bit fault);
    longint acc [3];
    longint t [3], r [3];
    longint wsum, d, w, s;
    int base;
    wsum = 0;
    for (int j = 0; j < 3; j++) acc[j] = 0;
    for (int c = 0; c < CORNER_COUNT; c++) begin
      base = BLEND_BASE + CORNER_WORDS * c;
      d = EPS_Q;
      for (int k = 0; k < 3; k++) begin
        t[k] = clamp32(v[k] - longint'(coef_shadow[base + k]));
        d += qmul(t[k], t[k]);
      end
      for (int j = 0; j < 3; j++) begin
        s = 0;
        for (int k = 0; k < 3; k++)
          s += qmul(longint'(coef_shadow[base + 3 + 3 * j + k]), t[k]);
        r[j] = clamp32(s);
      end
      // odd corners mirror in x, upper corners in y, corners 0 and 3 flip z
      if (c & 1) r[0] = clamp32(grid_w_shadow - r[0]);
      if (c & 2) r[1] = clamp32(grid_h_shadow - r[1]);
      if (c == 0 || c == 3) r[2] = clamp32(-r[2]);
      w = (64'sd1 <<< (2 * FRAC_BITS)) / d;
      for (int j = 0; j < 3; j++) acc[j] += qmul(w, r[j]);
      wsum += w;
    end
    for (int j = 0; j < 3; j++) res[j] = qquot(acc[j], wsum, fault);
  endfunction

  // applies one accepted beat to the shadow state, queues the frame it yields
  function automatic void predict_frame(beat_t b);
    frame_t f;
    longint p [3], n [3], o [6], rp [3], rn [3];
    longint u, v, hx, hy, hw;
    bit fault;
    fault = 1'b0;
    if (b.cmd == CMD_WRITE) begin
      if (b.idx < STORE_DEPTH) coef_shadow[b.idx] = b.val;
      return;
    end
    for (int k = 0; k < 3; k++) begin
      p[k] = b.pos[k];
      n[k] = b.nrm[k];
      o[k] = p[k];
      o[3 + k] = n[k];
    end
    if (mode_shadow == MODE_PLANAR) begin
      u = qquot(-p[1], p[0], fault);
      v = qquot(-p[2], p[0], fault);
      if (p[0] == 0) begin
        o[0] = u;
        o[1] = v;
      end else begin
        hx = clamp32(qmul(coef_shadow[0], u) + qmul(coef_shadow[1], v) + coef_shadow[2]);
        hy = clamp32(qmul(coef_shadow[3], u) + qmul(coef_shadow[4], v) + coef_shadow[5]);
        hw = clamp32(qmul(coef_shadow[6], u) + qmul(coef_shadow[7], v) + coef_shadow[8]);
        o[0] = qquot(hx, hw, fault);
        o[1] = qquot(hy, hw, fault);
      end
      for (int k = 2; k < 6; k++) o[k] = 0;
    end else if (mode_shadow == MODE_BLEND) begin
      corner_blend(p, rp, fault);
      corner_blend(n, rn, fault);
      for (int k = 0; k < 3; k++) begin
        o[k] = rp[k];
        o[3 + k] = rn[k];
      end
    end
    for (int k = 0; k < 6; k++) f.fld[k] = o[k][31:0];
    f.fault = fault;
    frame_q.push_back(f);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly modest values, with full range words and corner values mixed in
  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return $urandom_range(0, 2) - 1;
      3, 4:    return $urandom;
      default: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
    endcase
  endfunction

  task automatic queue_write(int idx, logic signed [31:0] val);
    beat_t b;
    b.cmd = CMD_WRITE;
    b.idx = idx;
    b.val = val;
    for (int k = 0; k < 3; k++) begin
      b.pos[k] = $urandom;
      b.nrm[k] = $urandom;
    end
    pending_q.push_back(b);
  endtask

  task automatic queue_point(logic signed [31:0] px, py, pz, nx, ny, nz);
    beat_t b;
    b.cmd = CMD_XFORM;
    b.idx = $urandom;
    b.val = $urandom;
    b.pos = '{px, py, pz};
    b.nrm = '{nx, ny, nz};
    pending_q.push_back(b);
  endtask

  // random mix of point beats and coefficient loads (some out of range)
  task automatic queue_random(int count, int write_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < write_pct)
        queue_write($urandom_range(0, 63), pick_word());
      else
        queue_point(pick_word(), pick_word(), pick_word(),
                    pick_word(), pick_word(), pick_word());
    end
  endtask

  // waits until every beat is sent and answered, then lets the block go idle
  task automatic drain();
    while (pending_q.size() != 0 || in_valid_i || frame_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [30:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_MODE:   mode_shadow   = data[1:0];
      CFG_GRID_W: grid_w_shadow = data;
      CFG_GRID_H: grid_h_shadow = data;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // clock, reset and run limit
  // ---------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(64'd20 * 64'd4_000_000);
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // driver: presents the next pending beat, holds it until accepted
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_ready_o) begin
      // beat still waiting, leave it alone
    end else if (pending_q.size() != 0 && !send_hold &&
                 $urandom_range(0, 99) >= send_idle_pct) begin
      cur_beat     <= pending_q[0];
      command_i    <= pending_q[0].cmd;
      coef_index_i <= pending_q[0].idx;
      coef_value_i <= pending_q[0].val;
      pos_x_i      <= pending_q[0].pos[0];
      pos_y_i      <= pending_q[0].pos[1];
      pos_z_i      <= pending_q[0].pos[2];
      norm_x_i     <= pending_q[0].nrm[0];
      norm_y_i     <= pending_q[0].nrm[1];
      norm_z_i     <= pending_q[0].nrm[2];
      in_valid_i   <= 1'b1;
      void'(pending_q.pop_front());
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // receiver backpressure
  always @(posedge clk_i) begin
    out_ready_i <= $urandom_range(0, 99) >= recv_idle_pct;
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on input beats, checks output beats in order
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    frame_t             want;
    logic signed [31:0] seen [6];
    if (rst_ni && in_valid_i && in_ready_o) predict_frame(cur_beat);
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen = '{out_x_o, out_y_o, out_z_o, out_nx_o, out_ny_o, out_nz_o};
      if (frame_q.size() == 0) begin
        $error("result beat with nothing expected");
        err_count++;
      end else begin
        want = frame_q.pop_front();
        for (int k = 0; k < 6; k++) begin
          if (seen[k] !== want.fld[k]) begin
            $error("%s expected %0d got %0d",
                   k == 0 ? "out_x" : k == 1 ? "out_y" : k == 2 ? "out_z" :
                   k == 3 ? "out_nx" : k == 4 ? "out_ny" : "out_nz",
                   want.fld[k], seen[k]);
            err_count++;
          end
        end
        if (divide_fault_o !== want.fault) begin
          $error("divide_fault expected %0d got %0d", want.fault, divide_fault_o);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    out_ready_i   = 1'b0;
    command_i     = CMD_WRITE;
    coef_index_i  = '0;
    coef_value_i  = '0;
    pos_x_i       = '0;
    pos_y_i       = '0;
    pos_z_i       = '0;
    norm_x_i      = '0;
    norm_y_i      = '0;
    norm_z_i      = '0;
    send_hold     = 1'b0;
    err_count     = 0;
    mode_shadow   = MODE_PASS;
    grid_w_shadow = 0;
    grid_h_shadow = 0;
    send_idle_pct = 9;
    recv_idle_pct = 51;
    for (int i = 0; i < STORE_DEPTH; i++) coef_shadow[i] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // pass through right after reset, field extremes
    queue_point(32'sh7fffffff, 32'sh80000000, 0, -1, 1, 32'sh7fffffff);
    queue_point(32'sh80000000, 32'sh7fffffff, -1, 32'sh80000000, 0, 1);
    // load every coefficient word before anything reads the store
    for (int i = 0; i < STORE_DEPTH; i++) queue_write(i, pick_word());
    queue_write(63, 32'sh7fffffff);  // beyond the store, ignored
    drain();

    // planar homography: identity-ish coefficients, then the corner cases
    write_reg(CFG_MODE, MODE_PLANAR);
    queue_write(0, 32'sh00010000);
    queue_write(4, 32'sh00010000);
    queue_write(8, 32'sh00010000);
    queue_point(32'sh00020000, 32'sh00010000, -32'sh00030000, 5, 6, 7);
    queue_point(0, 32'sh00010000, -32'sh00010000, 1, 1, 1);  // zero x
    queue_point(0, 0, 0, 0, 0, 0);                           // zero x, zero numerators
    queue_point(1, 32'sh7fffffff, 32'sh80000000, 0, 0, 0);   // quotient overflow
    queue_write(6, 0);
    queue_write(7, 0);
    queue_write(8, 0);
    queue_point(32'sh00010000, 32'sh00020000, 32'sh00030000, 0, 0, 0);  // zero third term
    queue_write(8, 32'sh00010000);
    queue_random(120, 20);
    drain();

    // 3d blend with an empty grid, sender held once until all results are back
    write_reg(CFG_MODE, MODE_BLEND);
    queue_point(0, 0, 0, 0, 0, 0);
    queue_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                32'sh80000000, 32'sh80000000, 32'sh80000000);  // far from every corner
    queue_random(60, 15);
    send_hold = 1'b1;
    while (frame_q.size() != 0 || in_valid_i) @(posedge clk_i);
    send_hold = 1'b0;
    queue_random(60, 15);
    drain();

    // swap the idle pattern, full grid
    send_idle_pct = 51;
    recv_idle_pct = 9;
    write_reg(CFG_GRID_W, 31'h7fffffff);
    write_reg(CFG_GRID_H, 31'h7fffffff);
    queue_random(130, 15);
    drain();
    write_reg(CFG_MODE, 2'd3);  // unused mode copies the inputs
    queue_random(50, 20);
    drain();

    // no idling from here on
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_MODE, MODE_PASS);
    queue_random(50, 20);
    drain();
    write_reg(CFG_MODE, MODE_PLANAR);
    queue_random(100, 20);
    drain();
    write_reg(CFG_MODE, MODE_BLEND);
    write_reg(CFG_GRID_W, $urandom_range(0, 32'h00400000));
    write_reg(CFG_GRID_H, $urandom_range(0, 32'h00400000));
    queue_random(110, 15);
    drain();

    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
design/mcft_pkg.sv
design/mcft_ram.sv
design/mcft_mul.sv
design/mcft_div.sv
design/marker_coordinate_frame_transform.sv
dv/testbench.sv
